[hw/rtl/fvwo_pkg.sv]
package fvwo_pkg;

  localparam int VOICE_COUNT = 4;
  localparam int STEP_W = 31;
  localparam int PHASE_W = 32;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_INDEX_W = 1;

  localparam logic [PHASE_W-1:0] HALF_PHASE = 32'd1073741824;
  localparam logic [PHASE_W-1:0] WAVE_PEAK = 32'd2147483647;
  // -3 * WAVE_PEAK modulo 2^32
  localparam logic [PHASE_W-1:0] TRI_OFFSET = 32'h8000_0003;
  localparam int COARSE_SHIFT = 24;
  localparam logic [3:0] VOLUME_SPAN = 4'd8;
  localparam logic [4:0] VOLUME_MAX = 5'd16;
  localparam logic [7:0] DAC_MIDPOINT = 8'd128;

  typedef enum logic [1:0] {
    WAVE_SAW      = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2
  } wave_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WAVE_MODE    = 1'd0,
    REG_VOLUME_LEVEL = 1'd1
  } reg_index_t;

  typedef struct packed {
    logic                positive;
    logic [PHASE_W-1:0] value;
  } lane_out_t;

endpackage

[hw/rtl/four_voice_waveform_oscillator.sv]
// An accepted beat updates the phase registers; their shaped values then load dac_sample.
// Throughput: one beat per cycle unless out_ready stalls; each lane's 32-bit
// phase add sets the first stage, the priority pick and volume shift into the
// output register the second. Reset clears all phase accumulators, sets
// wave_mode to sawtooth and volume_level to 16, and empties the pipeline.
module four_voice_waveform_oscillator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fvwo_pkg::STEP_W-1:0]        voice0_step,
  input  logic [fvwo_pkg::STEP_W-1:0]        voice1_step,
  input  logic [fvwo_pkg::STEP_W-1:0]        voice2_step,
  input  logic [fvwo_pkg::STEP_W-1:0]        voice3_step,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         dac_sample,
  input  logic                               cfg_write,
  input  logic [fvwo_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fvwo_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fvwo_pkg::*;

  wave_mode_t         wave_mode;
  logic [4:0]         volume_level;
  logic               s1_valid;
  logic               s1_move;
  logic               in_accept;
  logic [STEP_W-1:0]  steps [VOICE_COUNT];
  lane_out_t          lanes [VOICE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode    <= WAVE_SAW;
      volume_level <= VOLUME_MAX;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_WAVE_MODE:    wave_mode    <= wave_mode_t'(cfg_data[1:0]);
        REG_VOLUME_LEVEL: volume_level <= cfg_data;
        default:          ;
      endcase
    end
  end

  // phases hold the updated value until it moves into the output register
  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_move;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  assign steps[0] = voice0_step;
  assign steps[1] = voice1_step;
  assign steps[2] = voice2_step;
  assign steps[3] = voice3_step;

  for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_lane
    fvwo_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .advance   (in_accept),
      .step      (steps[g]),
      .wave_mode (wave_mode),
      .shaped    (lanes[g])
    );
  end

  fvwo_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (s1_move),
    .lanes        (lanes),
    .volume_level (volume_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dac_sample   (dac_sample)
  );

endmodule

[hw/rtl/fvwo_lane.sv]
module fvwo_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [fvwo_pkg::STEP_W-1:0]       step,
  input  fvwo_pkg::wave_mode_t              wave_mode,
  output fvwo_pkg::lane_out_t               shaped
);
  import fvwo_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_x4;
  logic               upper;
  logic [PHASE_W-1:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (advance) begin
      phase <= phase + {1'b0, step};
    end
  end

  assign phase_x4 = {phase[PHASE_W-3:0], 2'b00};
  assign upper    = $signed(phase) > $signed(HALF_PHASE);

  always_comb begin
    case (wave_mode)
      WAVE_SAW:      value = phase;
      WAVE_SQUARE:   value = upper ? WAVE_PEAK : '0;
      WAVE_TRIANGLE: value = upper ? (TRI_OFFSET + phase_x4) : (WAVE_PEAK - phase_x4);
      default:       value = '0;
    endcase
  end

  assign shaped.value    = value;
  assign shaped.positive = !value[PHASE_W-1] && (value != '0);

endmodule

[hw/rtl/fvwo_merge.sv]
module fvwo_merge (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  fvwo_pkg::lane_out_t     lanes [fvwo_pkg::VOICE_COUNT],
  input  logic [4:0]              volume_level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              dac_sample
);
  import fvwo_pkg::*;

  logic [PHASE_W-1:0] chosen;
  logic               found;
  logic [4:0]         vol_sat;
  logic [3:0]         shift;
  logic [7:0]         coarse;
  logic [7:0]         dac_sample_next;

  // first positive voice wins, lowest index first
  always_comb begin
    chosen = '0;
    found  = 1'b0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (!found && lanes[i].positive) begin
        chosen = lanes[i].value;
        found  = 1'b1;
      end
    end
  end

  assign vol_sat         = (volume_level > VOLUME_MAX) ? VOLUME_MAX : volume_level;
  assign shift           = VOLUME_SPAN - vol_sat[4:1];
  assign coarse          = chosen[PHASE_W-1:COARSE_SHIFT];
  assign dac_sample_next = (coarse >> shift) + DAC_MIDPOINT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dac_sample <= dac_sample_next;
    end
  end

endmodule
